/* hdl/pec15_frame_generate_check_core_assert.svh */
// Assertion macros for the frame code generator and checker.
`ifndef PEC15_FRAME_GENERATE_CHECK_CORE_ASSERT_SVH
`define PEC15_FRAME_GENERATE_CHECK_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PEC15_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PEC15_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/pec15_pkg.sv */
`timescale 1ns / 1ps
package pec15_pkg;

    localparam logic [15:0] CRC_SEED  = 16'h0010;
    localparam logic [15:0] CRC_POLY  = 16'h4599;
    localparam logic [1:0]  SEEN_MAX  = 2'd2;
    localparam int          RES_DEPTH = 3;

    typedef logic [1:0] res_count_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_code;
        logic       last;
        logic       code_ok;
    } result_t;

    typedef struct packed {
        logic       push;
        res_count_t count;
    } load_t;

endpackage

/* hdl/pec15_crc_step.sv */
`timescale 1ns / 1ps
module pec15_crc_step
    import pec15_pkg::*;
(
    input  logic [15:0] crc,
    input  logic [7:0]  data,
    output logic [15:0] crc_next
);

    logic [7:0]  idx;
    logic [15:0] entry;

    always_comb
    begin
        idx   = crc[14:7] ^ data;
        entry = {1'b0, idx, 7'b0000000};
        for (int k = 0; k < 8; k++)
        begin
            if (entry[14])
            begin
                entry = {entry[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                entry = {entry[14:0], 1'b0};
            end
        end
        crc_next = {crc[7:0], 8'h00} ^ entry;
    end

endmodule

/* hdl/pec15_frame_ctrl.sv */
`timescale 1ns / 1ps
module pec15_frame_ctrl
    import pec15_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       func,
    input  logic [7:0] data_byte,
    input  logic       frame_end,
    output result_t    results [RES_DEPTH],
    output load_t      load
);

    logic [15:0] crc_reg, crc_next;
    logic [7:0]  held0_reg, held0_next;
    logic [7:0]  held1_reg, held1_next;
    logic [1:0]  seen_reg, seen_next;
    logic        mode_reg, mode_next;

    logic        mode_cur;
    logic [7:0]  crc_byte;
    logic [15:0] crc_step;
    logic [15:0] crc_fed;
    logic [15:0] code;
    logic [1:0]  seen_inc;

    assign mode_cur = (seen_reg == 2'd0) ? func : mode_reg;
    assign crc_byte = mode_cur ? held0_reg : data_byte;
    assign seen_inc = (seen_reg == SEEN_MAX) ? SEEN_MAX : seen_reg + 2'd1;
    assign crc_fed  = (seen_reg == SEEN_MAX) ? crc_step : crc_reg;
    assign code     = {crc_step[14:0], 1'b0};

    pec15_crc_step u_crc (
        .crc      (crc_reg),
        .data     (crc_byte),
        .crc_next (crc_step)
    );

    always_comb
    begin
        crc_next   = crc_reg;
        held0_next = held0_reg;
        held1_next = held1_reg;
        seen_next  = seen_reg;
        mode_next  = mode_reg;
        for (int k = 0; k < RES_DEPTH; k++)
        begin
            results[k] = '0;
        end
        results[0].out_byte = data_byte;
        load.push  = accept;
        load.count = 2'd1;
        if (accept)
        begin
            mode_next = mode_cur;
            seen_next = seen_inc;
            if (!mode_cur)
            begin
                crc_next = crc_step;
                if (frame_end)
                begin
                    results[1] = '{out_byte: code[15:8], is_code: 1'b1,
                                   last: 1'b0, code_ok: 1'b0};
                    results[2] = '{out_byte: code[7:0], is_code: 1'b1,
                                   last: 1'b1, code_ok: 1'b0};
                    load.count = 2'd3;
                end
            end
            else
            begin
                crc_next   = crc_fed;
                held0_next = held1_reg;
                held1_next = data_byte;
                if (frame_end)
                begin
                    results[0].last    = 1'b1;
                    results[0].code_ok = (seen_inc == SEEN_MAX)
                        && ({held1_reg, data_byte} == {crc_fed[14:0], 1'b0});
                end
            end
            if (frame_end)
            begin
                crc_next   = CRC_SEED;
                held0_next = 8'h00;
                held1_next = 8'h00;
                seen_next  = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= CRC_SEED;
            held0_reg <= 8'h00;
            held1_reg <= 8'h00;
            seen_reg  <= 2'd0;
            mode_reg  <= 1'b0;
        end
        else
        begin
            crc_reg   <= crc_next;
            held0_reg <= held0_next;
            held1_reg <= held1_next;
            seen_reg  <= seen_next;
            mode_reg  <= mode_next;
        end
    end

endmodule

/* hdl/pec15_out_buf.sv */
`timescale 1ns / 1ps
module pec15_out_buf
    import pec15_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  load_t   load,
    input  result_t results [RES_DEPTH],
    input  logic    pop,
    output logic    ready,
    output logic    valid,
    output result_t head
);

    result_t    slot_reg [RES_DEPTH];
    result_t    slot_next [RES_DEPTH];
    res_count_t count_reg, count_next;

    assign valid = (count_reg != 2'd0);
    assign head  = slot_reg[0];
    assign ready = (count_reg == 2'd0) || ((count_reg == 2'd1) && pop);

    always_comb
    begin
        slot_next  = slot_reg;
        count_next = count_reg;
        if (load.push)
        begin
            slot_next  = results;
            count_next = load.count;
        end
        else if (pop)
        begin
            for (int k = 0; k < RES_DEPTH - 1; k++)
            begin
                slot_next[k] = slot_reg[k + 1];
            end
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

/* hdl/pec15_frame_generate_check_core.sv */
`timescale 1ns / 1ps
// PEC15 frame generator and checker: takes one frame byte per cycle unless
// stalled and echoes it in the next cycle, computing the 15-bit isoSPI packet
// error code (poly 0x4599, seed 0x0010, shifted left to 16 bits) with a CRC
// update per byte. The mode is latched from func on a frame's first byte. In
// generate mode the final byte yields three items (echo, code high, code low),
// which a three-entry result buffer plays out in order, so the byte after a
// generated frame waits until code low leaves; every other byte sustains one
// item per cycle unless the output stalls, since the buffer takes a new item
// as its last entry leaves. Check mode flags code_ok on the final byte's echo.
module pec15_frame_generate_check_core
    import pec15_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       func,
    input  logic [7:0] data_byte,
    input  logic       frame_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       is_code,
    output logic       last,
    output logic       code_ok
);

`include "pec15_frame_generate_check_core_assert.svh"

    logic    accept;
    logic    pop;
    logic    ready;
    load_t   load;
    result_t results [RES_DEPTH];
    result_t head;

    assign in_stall = !ready;
    assign accept   = in_valid && ready;
    assign pop      = out_valid && !out_stall;

    pec15_frame_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .func      (func),
        .data_byte (data_byte),
        .frame_end (frame_end),
        .results   (results),
        .load      (load)
    );

    pec15_out_buf u_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load),
        .results (results),
        .pop     (pop),
        .ready   (ready),
        .valid   (out_valid),
        .head    (head)
    );

    assign out_byte = head.out_byte;
    assign is_code  = head.is_code;
    assign last     = head.last;
    assign code_ok  = head.code_ok;

    `PEC15_ASSERT_NEXT(a_accept_gives_item, clk, rst_n, accept, out_valid, "no item after accept")
    `PEC15_ASSERT_NEXT(a_code_pair, clk, rst_n, pop && is_code && !last, out_valid && is_code && last, "code low byte missing")
    `PEC15_ASSERT_NOW(a_ok_on_last, clk, rst_n, out_valid && code_ok, last && !is_code, "code_ok off final echo")
    `PEC15_ASSERT_NOW(a_stall_busy, clk, rst_n, in_stall, out_valid, "stall with empty buffer")

endmodule

/* tb/sv/pec15_tb_pkg.sv */
`timescale 1ns / 1ps
package pec15_tb_pkg;
    import pec15_pkg::*;

    typedef enum logic {
        FUNC_APPEND = 1'b0,
        FUNC_CHECK  = 1'b1
    } frame_func_t;

    // bit-serial code over a whole byte list, used to build well-formed check frames
    function automatic logic [15:0] pec_code(logic [7:0] bytes[$]);
        logic [14:0] r;
        logic        din;
        r = CRC_SEED[14:0];
        foreach (bytes[i])
        begin
            for (int k = 7; k >= 0; k--)
            begin
                din = bytes[i][k] ^ r[14];
                r = {r[13:0], 1'b0};
                if (din)
                    r = r ^ CRC_POLY[14:0];
            end
        end
        return {r, 1'b0};
    endfunction

endpackage

/* tb/sv/pec15_frame_check.sv */
`timescale 1ns / 1ps
module pec15_frame_check
    import pec15_pkg::*;
    import pec15_tb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic       func,
    input  logic [7:0] data_byte,
    input  logic       frame_end,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] out_byte,
    input  logic       is_code,
    input  logic       last,
    input  logic       code_ok,
    output int         fail_count,
    output int         pending
);

    logic [15:0] crc_rem;
    logic [7:0]  held [2];
    logic [1:0]  seen;
    frame_func_t mode;
    result_t     expected_q[$];
    int          errors = 0;

    function automatic logic [15:0] crc_byte(logic [15:0] rem, logic [7:0] b);
        logic [15:0] t;
        t = {1'b0, rem[14:7] ^ b, 7'b0};
        for (int k = 0; k < 8; k++)
            t = t[14] ? ((t << 1) ^ CRC_POLY) : (t << 1);
        return (rem << 8) ^ t;
    endfunction

    task automatic report(string msg);
        if (errors < 50)
            $display("%0t check: %s", $time, msg);
        errors++;
    endtask

    task automatic predict_byte(frame_func_t f, logic [7:0] b, logic e);
        logic [15:0] code;
        logic        ok;
        if (seen == 2'd0)
            mode = f;
        if (mode == FUNC_APPEND)
        begin
            crc_rem = crc_byte(crc_rem, b);
            if (seen < SEEN_MAX)
                seen++;
            expected_q.push_back('{b, 1'b0, 1'b0, 1'b0});
            if (e)
            begin
                code = crc_rem << 1;
                expected_q.push_back('{code[15:8], 1'b1, 1'b0, 1'b0});
                expected_q.push_back('{code[7:0], 1'b1, 1'b1, 1'b0});
            end
        end
        else
        begin
            // the code trails the payload, so feed each byte two bytes late
            if (seen == SEEN_MAX)
                crc_rem = crc_byte(crc_rem, held[0]);
            held[0] = held[1];
            held[1] = b;
            if (seen < SEEN_MAX)
                seen++;
            code = crc_rem << 1;
            ok = e && (seen == SEEN_MAX) && ({held[0], held[1]} == code);
            expected_q.push_back('{b, 1'b0, e, ok});
        end
        if (e)
        begin
            crc_rem = CRC_SEED;
            held[0] = 8'h00;
            held[1] = 8'h00;
            seen = 2'd0;
        end
    endtask

    task automatic check_item();
        result_t want;
        if (expected_q.size() == 0)
        begin
            report($sformatf("item %02h with nothing expected", out_byte));
            return;
        end
        want = expected_q.pop_front();
        if (out_byte !== want.out_byte)
            report($sformatf("out_byte %02h, want %02h", out_byte, want.out_byte));
        if (is_code !== want.is_code)
            report($sformatf("is_code %b, want %b", is_code, want.is_code));
        if (last !== want.last)
            report($sformatf("last %b, want %b", last, want.last));
        if (code_ok !== want.code_ok)
            report($sformatf("code_ok %b, want %b", code_ok, want.code_ok));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_rem = CRC_SEED;
            held[0] = 8'h00;
            held[1] = 8'h00;
            seen = 2'd0;
            mode = FUNC_APPEND;
            expected_q.delete();
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_byte(frame_func_t'(func), data_byte, frame_end);
            if (out_valid && !out_stall)
                check_item();
            fail_count <= errors;
            pending <= expected_q.size();
        end
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
module tb;
    import pec15_pkg::*;
    import pec15_tb_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       func = 1'b0;
    logic [7:0] data_byte = 8'h00;
    logic       frame_end = 1'b0;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       is_code;
    logic       last;
    logic       code_ok;
    int         fail_count;
    int         pending;
    int         send_idle = 0;
    int         recv_idle = 0;
    int         sent = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pec15_frame_generate_check_core i_dut (.*);

    pec15_frame_check i_check (.*);

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_idle);

    task automatic send_byte(frame_func_t f, logic [7:0] b, logic e);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        data_byte <= b;
        frame_end <= e;
        do
            @(posedge clk);
        while (in_stall);
        sent++;
    endtask

    // func past the first byte is random: the block must ignore it
    task automatic send_frame(frame_func_t f, logic [7:0] body[$]);
        for (int i = 0; i < body.size(); i++)
            send_byte(i == 0 ? f : frame_func_t'($urandom_range(0, 1)), body[i],
                      i == body.size() - 1);
    endtask

    task automatic with_code(ref logic [7:0] body[$]);
        logic [15:0] code;
        code = pec_code(body);
        body.push_back(code[15:8]);
        body.push_back(code[7:0]);
    endtask

    task automatic random_frame();
        logic [7:0]  body[$];
        frame_func_t f;
        int          n;
        int          kind;
        int          idx;
        f = frame_func_t'($urandom_range(0, 1));
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 5);
        repeat (n)
            body.push_back(8'($urandom_range(0, 255)));
        if (f == FUNC_CHECK)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 17)
                with_code(body);
            if (kind >= 14 && kind < 17)
            begin
                idx = body.size() - 1 - $urandom_range(0, 1);
                body[idx] = body[idx] ^ (8'h01 << $urandom_range(0, 7));
            end
        end
        send_frame(f, body);
    endtask

    initial
    begin
        logic [7:0] body[$];
        int         stop;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        body = '{8'h00};
        send_frame(FUNC_APPEND, body);
        body = '{8'hff, 8'h5a, 8'ha5};
        send_frame(FUNC_APPEND, body);
        body = '{8'hff};
        send_frame(FUNC_CHECK, body);
        body.delete();
        with_code(body);
        send_frame(FUNC_CHECK, body);
        body = '{8'h01, 8'hfe};
        with_code(body);
        send_frame(FUNC_CHECK, body);
        body = '{8'h80, 8'h7f};
        with_code(body);
        body[3] = body[3] ^ 8'h01;
        send_frame(FUNC_CHECK, body);
        body = '{8'h55, 8'haa, 8'h00, 8'hff};
        send_frame(FUNC_CHECK, body);
        body = '{8'h12, 8'h34};
        send_frame(FUNC_APPEND, body);

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle = 9;
                    recv_idle = 56;
                end
                1:
                begin
                    send_idle = 56;
                    recv_idle = 9;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            stop = sent + 33;
            while (sent < stop)
                random_frame();
        end
        in_valid <= 1'b0;

        do
            @(posedge clk);
        while (pending != 0);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb: done, errors");
        $finish;
    end

endmodule
